[rtl/core/bffa_pkg.sv]
// Shared widths, operation and status codes, and the result type of the allocator.
`timescale 1ns / 1ps

package bffa_pkg;

  // Field widths of the request and result beats
  localparam int ENTRY_W  = 14;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // Default sizing of the usage bitmap
  localparam int MAX_ENTRIES_DEF   = 8192;
  localparam int BITS_PER_WORD_DEF = 8;

  // Entry count register after reset
  localparam logic [ENTRY_W-1:0] ENTRIES_RESET = 14'd8192;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
  localparam logic [OP_W-1:0] OP_MARK    = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_CONFLICT = 2'd3;

  // One result beat
  typedef struct packed {
    logic [ENTRY_W-1:0]  result_index;
    logic                used_flag;
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  free_count;
  } rsp_t;

endpackage

[rtl/core/bffa_req_if.sv]
// Request channel: operation code and one-based entry index with valid/ready.
`timescale 1ns / 1ps

interface bffa_req_if;
  import bffa_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [ENTRY_W-1:0] entry_index;

  modport source (output valid, output opcode, output entry_index, input ready);
  modport sink   (input valid, input opcode, input entry_index, output ready);
endinterface

[rtl/core/bffa_rsp_if.sv]
// Result channel: index, usage bit, status and free count with valid/ready.
`timescale 1ns / 1ps

interface bffa_rsp_if;
  import bffa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ENTRY_W-1:0]  result_index;
  logic                used_flag;
  logic [STATUS_W-1:0] status;
  logic [ENTRY_W-1:0]  free_count;

  modport source (output valid, output result_index, output used_flag, output status,
                  output free_count, input ready);
  modport sink   (input valid, input result_index, input used_flag, input status,
                  input free_count, output ready);
endinterface

[rtl/core/bffa_ram.sv]
// Usage bitmap storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module bffa_ram #(
  parameter int  WIDTH  = bffa_pkg::BITS_PER_WORD_DEF,
  parameter int  DEPTH  = bffa_pkg::MAX_ENTRIES_DEF / bffa_pkg::BITS_PER_WORD_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one word; the data is registered and valid in the next cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bffa_engine.sv]
// Sequencer: clears the bitmap, splits indexes, does read-modify-write and the free scan.
`timescale 1ns / 1ps

module bffa_engine #(
  parameter int  MAX_ENTRIES   = bffa_pkg::MAX_ENTRIES_DEF,
  parameter int  BITS_PER_WORD = bffa_pkg::BITS_PER_WORD_DEF,
  localparam int WORD_COUNT    = (MAX_ENTRIES + BITS_PER_WORD - 1) / BITS_PER_WORD,
  localparam int ADDR_W        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bffa_pkg::ENTRY_W-1:0] n_entries_i,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  logic [bffa_pkg::OP_W-1:0]    opcode_i,
  input  logic [bffa_pkg::ENTRY_W-1:0] entry_index_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output bffa_pkg::rsp_t               rsp_o,
  output logic                         mem_we_o,
  output logic [ADDR_W-1:0]            mem_waddr_o,
  output logic [BITS_PER_WORD-1:0]     mem_wdata_o,
  output logic                         mem_re_o,
  output logic [ADDR_W-1:0]            mem_raddr_o,
  input  logic [BITS_PER_WORD-1:0]     mem_rdata_i
);
  import bffa_pkg::*;

  localparam int BIT_W   = $clog2(BITS_PER_WORD);
  localparam int CNT_W   = $clog2(WORD_COUNT + 1);
  localparam int USED_W  = $clog2(MAX_ENTRIES + 1);
  // Reciprocal multiply: exact quotient for any ENTRY_W-bit dividend
  localparam int DIV_SH  = ENTRY_W + BIT_W + 1;
  localparam int RECIP   = ((1 << DIV_SH) + BITS_PER_WORD - 1) / BITS_PER_WORD;
  localparam int RECIP_W = DIV_SH + 1;
  localparam int PROD_W  = ENTRY_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  // Sequencer states
  localparam logic [2:0] S_CLR     = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_DIV     = 3'd2;
  localparam logic [2:0] S_SPLIT   = 3'd3;
  localparam logic [2:0] S_RMW     = 3'd4;
  localparam logic [2:0] S_SCAN_RD = 3'd5;
  localparam logic [2:0] S_SCAN_CK = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [ENTRY_W-1:0]  idx_q, idx_d;
  logic [ENTRY_W-1:0]  pos_q, pos_d;
  logic [ADDR_W-1:0]   word_q, word_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [CNT_W-1:0]    scan_q, scan_d;
  logic [CNT_W-1:0]    hint_q, hint_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [USED_W-1:0]   used_q, used_d;
  logic [ENTRY_W-1:0]  res_index_q, res_index_d;
  logic                res_used_q, res_used_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;

  logic [PROD_W-1:0]   prod;
  logic [ENTRY_W-1:0]  quot;
  logic [ENTRY_W-1:0]  word_base;
  logic [ENTRY_W-1:0]  rem;
  logic [ENTRY_W-1:0]  free_cnt;
  logic                cur_bit;
  logic [BIT_W-1:0]    zero_pos;
  logic                zero_found;
  logic [31:0]         scan_base;
  logic [31:0]         alloc_idx;

  // Split the zero-based position into word and bit
  assign prod      = PROD_W'(pos_q) * PROD_W'(RECIP_C);
  assign quot      = ENTRY_W'(prod >> DIV_SH);
  assign word_base = ENTRY_W'(32'(word_q) * BITS_PER_WORD);
  assign rem       = pos_q - word_base;

  // Free entries: effective count minus used, floored at zero
  always_comb begin
    if (32'(n_entries_i) > 32'(used_q)) begin
      free_cnt = ENTRY_W'(32'(n_entries_i) - 32'(used_q));
    end else begin
      free_cnt = '0;
    end
  end

  assign cur_bit = mem_rdata_i[bit_q];

  // Lowest clear bit of the word under scan
  always_comb begin
    zero_pos   = '0;
    zero_found = 1'b0;
    for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
      if (!mem_rdata_i[i]) begin
        zero_pos   = BIT_W'(i);
        zero_found = 1'b1;
      end
    end
  end

  assign scan_base = 32'(scan_q) * BITS_PER_WORD;
  assign alloc_idx = scan_base + 32'(zero_pos) + 32'd1;

  // Next state and memory access
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    word_d       = word_q;
    bit_d        = bit_q;
    scan_d       = scan_q;
    hint_d       = hint_q;
    clr_d        = clr_q;
    used_d       = used_q;
    res_index_d  = res_index_q;
    res_used_d   = res_used_q;
    res_status_d = res_status_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = word_q;
    mem_wdata_o  = mem_rdata_i;
    mem_re_o     = 1'b0;
    mem_raddr_o  = word_q;

    unique case (state_q)
      S_CLR: begin
        // Sweep zeros through the bitmap
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == ADDR_W'(WORD_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          op_d  = opcode_i;
          idx_d = entry_index_i;
          pos_d = entry_index_i - ENTRY_W'(1);
          if (opcode_i == OP_ALLOC) begin
            if (free_cnt == '0) begin
              res_index_d  = '0;
              res_used_d   = 1'b0;
              res_status_d = STATUS_FULL;
              state_d      = S_DONE;
            end else begin
              scan_d  = hint_q;
              state_d = S_SCAN_RD;
            end
          end else if (entry_index_i == '0 || entry_index_i > n_entries_i) begin
            res_index_d  = entry_index_i;
            res_used_d   = 1'b0;
            res_status_d = STATUS_RANGE;
            state_d      = S_DONE;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        word_d  = ADDR_W'(quot);
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        bit_d       = BIT_W'(rem);
        mem_re_o    = 1'b1;
        mem_raddr_o = word_q;
        state_d     = S_RMW;
      end
      S_RMW: begin
        res_index_d  = idx_q;
        res_used_d   = cur_bit;
        res_status_d = STATUS_OK;
        unique case (op_q)
          OP_RELEASE: begin
            if (!cur_bit) begin
              res_status_d = STATUS_CONFLICT;
            end else begin
              mem_we_o    = 1'b1;
              mem_wdata_o = mem_rdata_i & ~(BITS_PER_WORD'(1) << bit_q);
              used_d      = used_q - 1'b1;
              res_used_d  = 1'b0;
              if (32'(word_q) < 32'(hint_q)) begin
                hint_d = CNT_W'(word_q);
              end
            end
          end
          OP_MARK: begin
            if (cur_bit) begin
              res_status_d = STATUS_CONFLICT;
            end else begin
              mem_we_o    = 1'b1;
              mem_wdata_o = mem_rdata_i | (BITS_PER_WORD'(1) << bit_q);
              used_d      = used_q + 1'b1;
              res_used_d  = 1'b1;
            end
          end
          OP_ALLOC, OP_QUERY: begin
            res_used_d = cur_bit;
          end
        endcase
        state_d = S_DONE;
      end
      S_SCAN_RD: begin
        // Stop once the word starts past the last managed entry
        if (scan_base >= 32'(n_entries_i)) begin
          res_index_d  = '0;
          res_used_d   = 1'b0;
          res_status_d = STATUS_FULL;
          hint_d       = scan_q;
          state_d      = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = scan_q[ADDR_W-1:0];
          state_d     = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (!zero_found) begin
          scan_d  = scan_q + 1'b1;
          state_d = S_SCAN_RD;
        end else if (alloc_idx > 32'(n_entries_i)) begin
          res_index_d  = '0;
          res_used_d   = 1'b0;
          res_status_d = STATUS_FULL;
          hint_d       = scan_q;
          state_d      = S_DONE;
        end else begin
          mem_we_o     = 1'b1;
          mem_waddr_o  = scan_q[ADDR_W-1:0];
          mem_wdata_o  = mem_rdata_i | (BITS_PER_WORD'(1) << zero_pos);
          used_d       = used_q + 1'b1;
          res_index_d  = ENTRY_W'(alloc_idx);
          res_used_d   = 1'b1;
          res_status_d = STATUS_OK;
          hint_d       = scan_q;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_DONE);

  always_comb begin
    rsp_o.result_index = res_index_q;
    rsp_o.used_flag    = res_used_q;
    rsp_o.status       = res_status_q;
    rsp_o.free_count   = free_cnt;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      hint_q  <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      hint_q  <= hint_d;
      used_q  <= used_d;
    end
  end

  // Operation payload
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    word_q       <= word_d;
    bit_q        <= bit_d;
    scan_q       <= scan_d;
    res_index_q  <= res_index_d;
    res_used_q   <= res_used_d;
    res_status_q <= res_status_d;
  end

endmodule

[rtl/core/bffa_out_reg.sv]
// Output register: holds one result beat so the sequencer can take the next request.
`timescale 1ns / 1ps

module bffa_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bffa_pkg::rsp_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bffa_pkg::rsp_t out_data_o
);
  import bffa_pkg::*;

  logic valid_q, valid_d;
  rsp_t data_q;

  // Load when empty or when the held beat leaves this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/bitmap_first_fit_allocator_top.sv]
// Top level of the bitmap first-fit allocator: config register, sequencer, bitmap, output.
`timescale 1ns / 1ps

// Usage:
//   req_i carries one operation per beat (opcode, entry_index); rsp_o returns one
//   result beat per request, in order (result_index, used_flag, status, free_count).
//   cfg_we_i/cfg_wdata_i write the managed entry count; write it only while idle.
// Operation flow:
//   Release, query and mark pass from request beat to result beat through the index
//   split by reciprocal multiply (S_DIV, S_SPLIT), one bitmap read and, for a successful
//   release or mark, one write-back. An index of zero or past the entry count returns
//   straight from idle without a bitmap access. Allocate scans words from the
//   lowest-free hint up; each word costs one read and one check on the bitmap read
//   port. Allocate with no free entries returns without a scan.
//   One request is in flight at a time; the next is taken once the sequencer is idle,
//   even while a result waits in the output reg.
// Reset:
//   The bitmap is swept to zero one word per cycle over all WORD_COUNT words
//   (MAX_ENTRIES / BITS_PER_WORD rounded up, 1024 by default); req_i.ready
//   stays low meanwhile. The entry count resets to 8192 and the used count to zero.
// Stall:
//   A stalled receiver holds the result beat in the output register; the sequencer
//   then waits with its next result and accepts nothing more.
module bitmap_first_fit_allocator_top #(
  parameter int MAX_ENTRIES   = bffa_pkg::MAX_ENTRIES_DEF,
  parameter int BITS_PER_WORD = bffa_pkg::BITS_PER_WORD_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bffa_req_if.sink                     req_i,
  bffa_rsp_if.source                   rsp_o,
  input  logic                         cfg_we_i,
  input  logic [bffa_pkg::ENTRY_W-1:0] cfg_wdata_i
);
  import bffa_pkg::*;

  localparam int WORD_COUNT = (MAX_ENTRIES + BITS_PER_WORD - 1) / BITS_PER_WORD;
  localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  logic [ENTRY_W-1:0]       entries_q;
  logic [ENTRY_W-1:0]       n_eff;
  logic                     eng_valid;
  logic                     eng_ready;
  rsp_t                     eng_rsp;
  rsp_t                     out_rsp;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [BITS_PER_WORD-1:0] mem_wdata;
  logic                     mem_re;
  logic [ADDR_W-1:0]        mem_raddr;
  logic [BITS_PER_WORD-1:0] mem_rdata;

  // Entry count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= ENTRIES_RESET;
    end else if (cfg_we_i) begin
      entries_q <= cfg_wdata_i;
    end
  end

  // Cap the entry count at the bitmap size
  always_comb begin
    if (32'(entries_q) > 32'(MAX_ENTRIES)) begin
      n_eff = ENTRY_W'(MAX_ENTRIES);
    end else begin
      n_eff = entries_q;
    end
  end

  bffa_engine #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .BITS_PER_WORD (BITS_PER_WORD)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_entries_i   (n_eff),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .opcode_i      (req_i.opcode),
    .entry_index_i (req_i.entry_index),
    .rsp_valid_o   (eng_valid),
    .rsp_ready_i   (eng_ready),
    .rsp_o         (eng_rsp),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  bffa_ram #(
    .WIDTH (BITS_PER_WORD),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bffa_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (eng_valid),
    .in_ready_o  (eng_ready),
    .in_data_i   (eng_rsp),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (out_rsp)
  );

  // Drive the result channel payload
  assign rsp_o.result_index = out_rsp.result_index;
  assign rsp_o.used_flag    = out_rsp.used_flag;
  assign rsp_o.status       = out_rsp.status;
  assign rsp_o.free_count   = out_rsp.free_count;

endmodule

[tb/bffa_result_checker.sv]
// Checker for the allocator: predicts each result beat from the requests and compares it.
`timescale 1ns / 1ps

module bffa_result_checker #(
  parameter int MAX_ENTRIES = bffa_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bffa_req_if                          req_mon,
  bffa_rsp_if                          rsp_mon,
  input  logic                         cfg_we_i,
  input  logic [bffa_pkg::ENTRY_W-1:0] cfg_wdata_i,
  output int                           fail_count_o,
  output int unsigned                  result_count_o
);
  import bffa_pkg::*;

  // Shadow of the usage bitmap, bit k is entry k+1
  bit [MAX_ENTRIES-1:0] usage_map;
  int unsigned          used_total;
  logic [ENTRY_W-1:0]   entry_reg;

  rsp_t awaited_results[$];
  rsp_t oldest_rsp;

  function automatic int unsigned managed_entries();
    return (entry_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_reg);
  endfunction

  // Free count saturates at zero once the entry count was lowered below the used count
  function automatic int unsigned free_entries();
    int unsigned n;
    n = managed_entries();
    return (n > used_total) ? n - used_total : 0;
  endfunction

  // Apply one operation to the shadow state and return the result beat it yields
  function automatic rsp_t bitmap_op_result(input logic [OP_W-1:0] op,
                                            input logic [ENTRY_W-1:0] idx);
    rsp_t        r;
    int unsigned n;
    bit          cur;
    n = managed_entries();
    r = '0;
    if (op == OP_ALLOC) begin
      r.status = STATUS_FULL;
      if (free_entries() > 0) begin
        for (int unsigned i = 1; i <= n; i++) begin
          if (!usage_map[i-1]) begin
            usage_map[i-1] = 1'b1;
            used_total++;
            r.result_index = ENTRY_W'(i);
            r.used_flag    = 1'b1;
            r.status       = STATUS_OK;
            break;
          end
        end
      end
    end else begin
      r.result_index = idx;
      if (idx == 0 || idx > n) begin
        r.status = STATUS_RANGE;
      end else begin
        cur         = usage_map[idx-1];
        r.used_flag = cur;
        if (op == OP_RELEASE) begin
          if (!cur) begin
            r.status = STATUS_CONFLICT;
          end else begin
            usage_map[idx-1] = 1'b0;
            if (used_total > 0) used_total--;
            r.used_flag = 1'b0;
          end
        end else if (op == OP_MARK) begin
          if (cur) begin
            r.status = STATUS_CONFLICT;
          end else begin
            usage_map[idx-1] = 1'b1;
            used_total++;
            r.used_flag = 1'b1;
          end
        end
      end
    end
    r.free_count = ENTRY_W'(free_entries());
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    fail_count_o++;
  endtask

  // Watch both channels and the register port; retire result beats before new requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usage_map      = '0;
      used_total     = 0;
      entry_reg      = ENTRIES_RESET;
      fail_count_o   = 0;
      result_count_o = 0;
      awaited_results.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        result_count_o++;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result beat index %0d with no request pending",
                                    rsp_mon.result_index));
        end else begin
          oldest_rsp = awaited_results.pop_front();
          if (rsp_mon.result_index !== oldest_rsp.result_index)
            report_mismatch($sformatf("result_index got %0d want %0d",
                                      rsp_mon.result_index, oldest_rsp.result_index));
          if (rsp_mon.used_flag !== oldest_rsp.used_flag)
            report_mismatch($sformatf("used_flag got %0d want %0d (index %0d)",
                                      rsp_mon.used_flag, oldest_rsp.used_flag,
                                      oldest_rsp.result_index));
          if (rsp_mon.status !== oldest_rsp.status)
            report_mismatch($sformatf("status got %0d want %0d (index %0d)",
                                      rsp_mon.status, oldest_rsp.status,
                                      oldest_rsp.result_index));
          if (rsp_mon.free_count !== oldest_rsp.free_count)
            report_mismatch($sformatf("free_count got %0d want %0d (index %0d)",
                                      rsp_mon.free_count, oldest_rsp.free_count,
                                      oldest_rsp.result_index));
        end
      end
      if (req_mon.valid && req_mon.ready)
        awaited_results.push_back(bitmap_op_result(req_mon.opcode, req_mon.entry_index));
      if (cfg_we_i)
        entry_reg = cfg_wdata_i;
    end
  end

endmodule

[tb/bitmap_first_fit_allocator_top_test.sv]
// Stimulus and verdict for the bitmap first-fit allocator: directed and random operations.
`timescale 1ns / 1ps

module bitmap_first_fit_allocator_top_test;
  import bffa_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS  = 68;
  localparam int unsigned INDEX_MAX    = (1 << ENTRY_W) - 1;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [ENTRY_W-1:0] cfg_wdata_i;

  bffa_req_if req_bus ();
  bffa_rsp_if rsp_bus ();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned sent_beats;
  int unsigned managed;
  int unsigned quiet_cycles = 0;
  int          fail_count;
  int unsigned result_beats;

  // Entry counts per random phase: small, single, saturated, zero and full sizes
  int unsigned phase_entries [10] = '{8, 1, 16, 64, 8192, 16383, 40, 0, 100, 8192};

  always #5 clk_i = ~clk_i;

  bitmap_first_fit_allocator_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bffa_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_bus),
    .rsp_mon        (rsp_bus),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_count_o   (fail_count),
    .result_count_o (result_beats)
  );

  // Stall the result channel at random
  always @(posedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Count cycles without any beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("** bitmap_first_fit_allocator_top: FAILED **");
    $finish;
  end

  // Present one request beat and hold it until accepted; valid stays high afterwards
  task automatic send_op(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.opcode      <= op;
    req_bus.entry_index <= idx;
    do @(posedge clk_i); while (!req_bus.ready);
    sent_beats++;
  endtask

  // Drop valid and wait until every request has its result beat
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (result_beats < sent_beats);
  endtask

  task automatic write_entries(input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ENTRY_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    managed = (value > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : value;
  endtask

  task automatic set_idle(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  // Random operation; indexes mostly land in a low window so entries get reused
  task automatic random_op();
    int unsigned        roll;
    int unsigned        window;
    logic [OP_W-1:0]    op;
    logic [ENTRY_W-1:0] idx;
    roll = $urandom_range(99);
    if (roll < 35) op = OP_ALLOC;
    else if (roll < 65) op = OP_RELEASE;
    else if (roll < 80) op = OP_QUERY;
    else op = OP_MARK;
    window = (managed < 64) ? managed : 64;
    roll = $urandom_range(99);
    if (op == OP_ALLOC || roll < 6) idx = ENTRY_W'($urandom_range(INDEX_MAX, 0));
    else if (roll < 10) idx = '0;
    else if (roll < 14) idx = ENTRY_W'(managed + 1);
    else if (managed == 0) idx = ENTRY_W'($urandom_range(INDEX_MAX, 0));
    else if (roll < 24) idx = ENTRY_W'($urandom_range(managed, 1));
    else idx = ENTRY_W'($urandom_range(window, 1));
    send_op(op, idx);
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    req_bus.valid       = 1'b0;
    req_bus.opcode      = OP_ALLOC;
    req_bus.entry_index = '0;
    sent_beats          = 0;
    managed             = MAX_ENTRIES_DEF;
    set_idle(0);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Range edges and conflicts at the reset entry count
    send_op(OP_QUERY, '0);
    send_op(OP_QUERY, 14'd8192);
    send_op(OP_QUERY, 14'd8193);
    send_op(OP_QUERY, ENTRY_W'(INDEX_MAX));
    send_op(OP_RELEASE, 14'd1);
    send_op(OP_MARK, 14'd8192);
    send_op(OP_MARK, 14'd8192);
    send_op(OP_RELEASE, 14'd8192);
    // Lowest-free search, reuse of a released hole, skip over a marked entry
    send_op(OP_ALLOC, ENTRY_W'(INDEX_MAX));
    send_op(OP_ALLOC, '0);
    send_op(OP_ALLOC, 14'd77);
    send_op(OP_RELEASE, 14'd2);
    send_op(OP_ALLOC, '0);
    send_op(OP_MARK, 14'd5);
    send_op(OP_ALLOC, '0);
    send_op(OP_ALLOC, '0);

    // Zero entries: everything out of range, allocate full
    wait_drained();
    write_entries(0);
    send_op(OP_ALLOC, '0);
    send_op(OP_QUERY, 14'd1);

    // Count lowered below the used count: free count saturates, bits above stay used
    wait_drained();
    write_entries(4);
    send_op(OP_ALLOC, '0);
    send_op(OP_RELEASE, 14'd3);
    send_op(OP_ALLOC, '0);

    // Register above the bitmap size saturates
    wait_drained();
    write_entries(INDEX_MAX);
    send_op(OP_QUERY, 14'd8192);
    send_op(OP_QUERY, 14'd8193);
    send_op(OP_RELEASE, 14'd5);
    send_op(OP_RELEASE, 14'd6);

    // Random phases, each with its own entry count and idle pattern
    for (int p = 0; p < 10; p++) begin
      wait_drained();
      write_entries(phase_entries[p]);
      set_idle(p % 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold the sender once mid-phase until all results are back
        if (p == 5 && i == PHASE_ITEMS / 2) wait_drained();
        random_op();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** bitmap_first_fit_allocator_top: PASSED **");
    end else begin
      $display("** bitmap_first_fit_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

[bitmap_first_fit_allocator_top.f]
rtl/core/bffa_pkg.sv
rtl/core/bffa_req_if.sv
rtl/core/bffa_rsp_if.sv
rtl/core/bffa_ram.sv
rtl/core/bffa_engine.sv
rtl/core/bffa_out_reg.sv
rtl/core/bitmap_first_fit_allocator_top.sv
tb/bffa_result_checker.sv
tb/bitmap_first_fit_allocator_top_test.sv
